### sv/lpcd_pkg.sv
package lpcd_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int MAX_OUT  = 16;
  localparam int FLUSH_W  = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int PAGE_W   = 32;
  localparam int LIMIT_W  = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // request kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  // update broadcast to the cells
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_TOUCH,
    ACT_TOUCH_DIRTY,
    ACT_ALLOC_FREE,
    ACT_ALLOC_VICTIM,
    ACT_CLEAN
  } act_t;

  typedef struct packed {
    act_t              act;
    logic [PAGE_W-1:0] page_id;
    logic [IDX_W-1:0]  hit_rank;
    logic [IDX_W-1:0]  lru_rank;
  } cell_cmd_t;

  // priority flags handed from cell to cell
  typedef struct packed {
    logic hit_seen;
    logic free_seen;
    logic dirty_seen;
  } chain_t;

  typedef struct packed {
    logic              match_sel;
    logic              free_sel;
    logic              lru;
    logic              dirty_sel;
    logic              dirty;
    logic [PAGE_W-1:0] page;
    logic [IDX_W-1:0]  rank;
  } cell_stat_t;

  function automatic logic [3:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+3:0] w;
    w = {4'b0, idx};
    return w[3:0];
  endfunction

endpackage

### sv/lpcd_cell.sv
module lpcd_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lpcd_pkg::cell_cmd_t  cmd,
  input  lpcd_pkg::chain_t     chain_in,
  output lpcd_pkg::chain_t     chain_out,
  output lpcd_pkg::cell_stat_t stat
);

  logic                          valid_r, valid_nxt;
  logic                          dirty_r, dirty_nxt;
  logic [lpcd_pkg::PAGE_W-1:0]   page_r, page_nxt;
  logic [lpcd_pkg::IDX_W-1:0]    rank_r, rank_nxt;

  logic match, free, dirty_here;

  assign match      = valid_r && (page_r == cmd.page_id);
  assign free       = !valid_r;
  assign dirty_here = valid_r && dirty_r;

  assign chain_out.hit_seen   = chain_in.hit_seen   | match;
  assign chain_out.free_seen  = chain_in.free_seen  | free;
  assign chain_out.dirty_seen = chain_in.dirty_seen | dirty_here;

  assign stat.match_sel = match && !chain_in.hit_seen;
  assign stat.free_sel  = free && !chain_in.free_seen;
  assign stat.dirty_sel = dirty_here && !chain_in.dirty_seen;
  assign stat.lru       = valid_r && (rank_r == cmd.lru_rank);
  assign stat.dirty     = dirty_r;
  assign stat.page      = page_r;
  assign stat.rank      = rank_r;

  always_comb begin
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    page_nxt  = page_r;
    rank_nxt  = rank_r;
    unique case (cmd.act)
      lpcd_pkg::ACT_TOUCH, lpcd_pkg::ACT_TOUCH_DIRTY: begin
        if (stat.match_sel) begin
          rank_nxt = '0;
          if (cmd.act == lpcd_pkg::ACT_TOUCH_DIRTY) dirty_nxt = 1'b1;
        end else if (valid_r && (rank_r < cmd.hit_rank)) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      lpcd_pkg::ACT_ALLOC_FREE, lpcd_pkg::ACT_ALLOC_VICTIM: begin
        if ((cmd.act == lpcd_pkg::ACT_ALLOC_FREE) ? stat.free_sel : stat.lru) begin
          valid_nxt = 1'b1;
          dirty_nxt = 1'b0;
          page_nxt  = cmd.page_id;
          rank_nxt  = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      lpcd_pkg::ACT_CLEAN: begin
        if (stat.dirty_sel) dirty_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
    rank_r <= rank_nxt;
  end

endmodule

### sv/lru_page_cache_directory.sv
// a request is captured, then each lookup/update pass writes one result, and a pass waits
// while a stalled result is held; read and write give one result each, a flush one per dirty
// page (at most 16) and a single empty result when no page is dirty; one request at a time
// each result comes from a single lookup/update pass through the chain of entry cells
// reset (synchronous, rst_n low): all entries invalid and clean, pages held 0, page limit 16
// no clearing pass after reset; the block accepts requests as soon as rst_n is high
module lru_page_cache_directory (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_page_id,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [3:0]  out_slot,
  output logic        out_victim_valid,
  output logic [31:0] out_victim_page,
  output logic        out_victim_dirty,
  output logic        out_write_through,
  output logic        out_flush_valid,
  output logic [31:0] out_flush_page,
  output logic        out_last,
  // page limit register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  localparam int CAP = lpcd_pkg::CAPACITY;
  localparam int IW  = lpcd_pkg::IDX_W;
  localparam int CW  = lpcd_pkg::CNT_W;
  localparam int FW  = lpcd_pkg::FLUSH_W;

  // one-hot fsm: idle waits for a request, exec runs one pass per result
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // captured request
  logic [1:0]  kind_r;
  logic [31:0] page_id_r;

  logic [lpcd_pkg::LIMIT_W-1:0] page_limit_r;
  logic [CW-1:0]                held_r, held_nxt;
  logic [FW-1:0]                flush_n_r, flush_n_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic        hit_r, hit_nxt;
  logic [3:0]  slot_r, slot_nxt;
  logic        vv_r, vv_nxt;
  logic [31:0] vp_r, vp_nxt;
  logic        vd_r, vd_nxt;
  logic        wt_r, wt_nxt;
  logic        fv_r, fv_nxt;
  logic [31:0] fp_r, fp_nxt;
  logic        last_r, last_nxt;

  // cell row
  lpcd_pkg::cell_cmd_t  cmd;
  lpcd_pkg::chain_t     chain [CAP+1];
  lpcd_pkg::cell_stat_t stat  [CAP];

  logic in_fire, fire;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  // a pass can run when the result register is empty or being drained
  assign fire      = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);

  assign chain[0] = '0;

  for (genvar g = 0; g < CAP; g++) begin : g_cell
    lpcd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .stat      (stat[g])
    );
  end

  // gather what the row reports: one-hot selects become index and data
  logic [IW-1:0] hit_idx, free_idx, lru_idx, dirty_idx, hit_rank;
  logic [31:0]   lru_page, dirty_page;
  logic          lru_dirty;

  always_comb begin
    hit_idx     = '0;
    free_idx    = '0;
    lru_idx     = '0;
    dirty_idx   = '0;
    hit_rank    = '0;
    lru_page    = '0;
    lru_dirty   = 1'b0;
    dirty_page  = '0;
    for (int i = 0; i < CAP; i++) begin
      if (stat[i].match_sel) begin
        hit_idx  = hit_idx | IW'(i);
        hit_rank = hit_rank | stat[i].rank;
      end
      if (stat[i].free_sel) free_idx = free_idx | IW'(i);
      if (stat[i].lru) begin
        lru_idx   = lru_idx | IW'(i);
        lru_page  = lru_page | stat[i].page;
        lru_dirty = lru_dirty | stat[i].dirty;
      end
      if (stat[i].dirty_sel) begin
        dirty_idx  = dirty_idx | IW'(i);
        dirty_page = dirty_page | stat[i].page;
      end
    end
  end

  // dirty entries other than the one being flushed; the dirty mark is only
  // ever set on a valid entry
  logic [CAP-1:0] dirty_sel_vec, vd_vec;
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      vd_vec[i]        = stat[i].dirty;
      dirty_sel_vec[i] = stat[i].dirty_sel;
    end
  end

  logic any_hit, any_free, any_dirty, more_dirty;
  assign any_hit    = chain[CAP].hit_seen;
  assign any_free   = chain[CAP].free_seen;
  assign any_dirty  = chain[CAP].dirty_seen;
  assign more_dirty = |(vd_vec & ~dirty_sel_vec);

  // effective limit: zero acts as one, above capacity acts as capacity
  logic [7:0] lim8, held8;
  logic       evict;
  logic [CW-1:0] held_m1;

  always_comb begin
    lim8 = 8'(page_limit_r);
    if (lim8 == 8'd0) lim8 = 8'd1;
    if (lim8 > 8'(CAP)) lim8 = 8'(CAP);
  end

  assign held8   = 8'(held_r);
  assign evict   = (held8 >= lim8) || !any_free;
  // the least recent entry always holds rank pages_held - 1
  assign held_m1 = held_r - CW'(1);

  always_comb begin
    cmd.act      = lpcd_pkg::ACT_NONE;
    cmd.page_id  = page_id_r;
    cmd.hit_rank = hit_rank;
    cmd.lru_rank = held_m1[IW-1:0];

    state_nxt   = state_r;
    held_nxt    = held_r;
    flush_n_nxt = flush_n_r;

    out_valid_nxt = out_valid_r && out_stall;
    hit_nxt  = hit_r;
    slot_nxt = slot_r;
    vv_nxt   = vv_r;
    vp_nxt   = vp_r;
    vd_nxt   = vd_r;
    wt_nxt   = wt_r;
    fv_nxt   = fv_r;
    fp_nxt   = fp_r;
    last_nxt = last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt   = ST_EXEC;
          flush_n_nxt = '0;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          out_valid_nxt = 1'b1;
          hit_nxt  = 1'b0;
          slot_nxt = '0;
          vv_nxt   = 1'b0;
          vp_nxt   = '0;
          vd_nxt   = 1'b0;
          wt_nxt   = 1'b0;
          fv_nxt   = 1'b0;
          fp_nxt   = '0;
          last_nxt = 1'b1;
          state_nxt = ST_IDLE;
          case (kind_r)
            lpcd_pkg::KIND_READ: begin
              if (any_hit) begin
                cmd.act  = lpcd_pkg::ACT_TOUCH;
                hit_nxt  = 1'b1;
                slot_nxt = lpcd_pkg::to_slot(hit_idx);
              end else if (evict) begin
                // victim entry is reused, count unchanged
                cmd.act  = lpcd_pkg::ACT_ALLOC_VICTIM;
                slot_nxt = lpcd_pkg::to_slot(lru_idx);
                vv_nxt   = 1'b1;
                vp_nxt   = lru_page;
                vd_nxt   = lru_dirty;
              end else begin
                cmd.act  = lpcd_pkg::ACT_ALLOC_FREE;
                slot_nxt = lpcd_pkg::to_slot(free_idx);
                held_nxt = held_r + CW'(1);
              end
            end
            lpcd_pkg::KIND_WRITE: begin
              if (any_hit) begin
                cmd.act  = lpcd_pkg::ACT_TOUCH_DIRTY;
                hit_nxt  = 1'b1;
                slot_nxt = lpcd_pkg::to_slot(hit_idx);
              end else begin
                wt_nxt = 1'b1;
              end
            end
            lpcd_pkg::KIND_FLUSH: begin
              if (any_dirty) begin
                cmd.act     = lpcd_pkg::ACT_CLEAN;
                slot_nxt    = lpcd_pkg::to_slot(dirty_idx);
                fv_nxt      = 1'b1;
                fp_nxt      = dirty_page;
                flush_n_nxt = flush_n_r + FW'(1);
                // stop at the last dirty page or at the per-request cap
                if (more_dirty && (flush_n_r != FW'(lpcd_pkg::MAX_OUT - 1))) begin
                  last_nxt  = 1'b0;
                  state_nxt = ST_EXEC;
                end
              end
            end
            default: ;
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      held_r       <= '0;
      flush_n_r    <= '0;
      page_limit_r <= lpcd_pkg::LIMIT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      flush_n_r   <= flush_n_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) page_limit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r    <= in_kind;
      page_id_r <= in_page_id;
    end
    hit_r  <= hit_nxt;
    slot_r <= slot_nxt;
    vv_r   <= vv_nxt;
    vp_r   <= vp_nxt;
    vd_r   <= vd_nxt;
    wt_r   <= wt_nxt;
    fv_r   <= fv_nxt;
    fp_r   <= fp_nxt;
    last_r <= last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = hit_r;
  assign out_slot          = slot_r;
  assign out_victim_valid  = vv_r;
  assign out_victim_page   = vp_r;
  assign out_victim_dirty  = vd_r;
  assign out_write_through = wt_r;
  assign out_flush_valid   = fv_r;
  assign out_flush_page    = fp_r;
  assign out_last          = last_r;

endmodule

### sv/lpcd_chk.sv
module lpcd_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_kind,
  input logic [31:0] in_page_id,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit,
  input logic [3:0]  out_slot,
  input logic        out_victim_valid,
  input logic [31:0] out_victim_page,
  input logic        out_victim_dirty,
  input logic        out_write_through,
  input logic        out_flush_valid,
  input logic [31:0] out_flush_page,
  input logic        out_last,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [4:0]  cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_slot) && $stable(out_last)
      && $stable(out_victim_page) && $stable(out_flush_page))
    else $error("stalled result changed");

  // one request at a time: the cycle after an accepted transaction is busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while busy");

  // only a flush sweep produces more than one result
  a_multi_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_flush_valid)
    else $error("non-final result that is not a flush");

  // result kinds exclude each other
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_hit, out_victim_valid, out_write_through,
                              out_flush_valid}) <= 1)
    else $error("conflicting result flags");

endmodule

bind lru_page_cache_directory lpcd_chk u_lpcd_chk (.*);

### tb/sv/lru_directory_checker.sv
`timescale 1ns / 1ps

module lru_directory_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_page_id,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_hit,
  input  logic [3:0]  out_slot,
  input  logic        out_victim_valid,
  input  logic [31:0] out_victim_page,
  input  logic        out_victim_dirty,
  input  logic        out_write_through,
  input  logic        out_flush_valid,
  input  logic [31:0] out_flush_page,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  output int          mismatches,
  output int          replies_pending
);

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic        victim_valid;
    logic [31:0] victim_page;
    logic        victim_dirty;
    logic        write_through;
    logic        flush_valid;
    logic [31:0] flush_page;
    logic        last;
  } dir_reply_t;

  // private copy of the directory
  logic              slot_used  [lpcd_pkg::CAPACITY];
  logic [31:0]       slot_page  [lpcd_pkg::CAPACITY];
  logic              slot_dirty [lpcd_pkg::CAPACITY];
  int unsigned       slot_age   [lpcd_pkg::CAPACITY];
  int                n_held;
  logic [lpcd_pkg::LIMIT_W-1:0] lim_reg;

  dir_reply_t replies_due [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %0s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic queue_reply(input dir_reply_t r);
    replies_due = {replies_due, r};
  endtask

  task automatic clear_directory();
    for (int i = 0; i < lpcd_pkg::CAPACITY; i++) begin
      slot_used[i]  = 1'b0;
      slot_page[i]  = '0;
      slot_dirty[i] = 1'b0;
      slot_age[i]   = 0;
    end
    n_held  = 0;
    lim_reg = lpcd_pkg::LIMIT_RESET;
    replies_due.delete();
  endtask

  function automatic int cap_limit();
    if (lim_reg == 0) return 1;
    if (lim_reg > lpcd_pkg::CAPACITY) return lpcd_pkg::CAPACITY;
    return int'(lim_reg);
  endfunction

  function automatic int find_slot(input logic [31:0] page);
    for (int i = 0; i < lpcd_pkg::CAPACITY; i++)
      if (slot_used[i] && slot_page[i] == page) return i;
    return -1;
  endfunction

  function automatic int first_free();
    for (int i = 0; i < lpcd_pkg::CAPACITY; i++)
      if (!slot_used[i]) return i;
    return -1;
  endfunction

  function automatic int oldest_slot();
    int best;
    best = -1;
    for (int i = 0; i < lpcd_pkg::CAPACITY; i++)
      if (slot_used[i] && (best < 0 || slot_age[i] > slot_age[best])) best = i;
    return best;
  endfunction

  task automatic touch(input int s);
    int unsigned a;
    a = slot_age[s];
    for (int i = 0; i < lpcd_pkg::CAPACITY; i++)
      if (slot_used[i] && slot_age[i] < a) slot_age[i]++;
    slot_age[s] = 0;
  endtask

  task automatic apply_request(input logic [1:0] kind, input logic [31:0] page);
    dir_reply_t r;
    int s, v, n, total;
    r = '0;
    r.last = 1'b1;
    case (kind)
      lpcd_pkg::KIND_READ: begin
        s = find_slot(page);
        if (s >= 0) begin
          touch(s);
          r.hit  = 1'b1;
          r.slot = s[3:0];
        end else begin
          s = first_free();
          if (n_held + 1 > cap_limit() || s < 0) begin
            v = oldest_slot();
            if (v >= 0) begin
              r.victim_valid = 1'b1;
              r.victim_page  = slot_page[v];
              r.victim_dirty = slot_dirty[v];
              slot_used[v]   = 1'b0;
              slot_dirty[v]  = 1'b0;
              if (n_held > 0) n_held--;
              s = v;
            end
          end
          if (s < 0) s = 0;
          for (int i = 0; i < lpcd_pkg::CAPACITY; i++)
            if (slot_used[i]) slot_age[i]++;
          slot_used[s]  = 1'b1;
          slot_page[s]  = page;
          slot_dirty[s] = 1'b0;
          slot_age[s]   = 0;
          n_held++;
          r.slot = s[3:0];
        end
        queue_reply(r);
      end
      lpcd_pkg::KIND_WRITE: begin
        s = find_slot(page);
        if (s >= 0) begin
          slot_dirty[s] = 1'b1;
          touch(s);
          r.hit  = 1'b1;
          r.slot = s[3:0];
        end else begin
          r.write_through = 1'b1;
        end
        queue_reply(r);
      end
      lpcd_pkg::KIND_FLUSH: begin
        total = 0;
        for (int i = 0; i < lpcd_pkg::CAPACITY; i++)
          if (slot_used[i] && slot_dirty[i]) total++;
        if (total > lpcd_pkg::MAX_OUT) total = lpcd_pkg::MAX_OUT;
        if (total == 0) begin
          queue_reply(r);
        end else begin
          n = 0;
          for (int i = 0; i < lpcd_pkg::CAPACITY && n < lpcd_pkg::MAX_OUT; i++) begin
            if (slot_used[i] && slot_dirty[i]) begin
              n++;
              r             = '0;
              r.slot        = i[3:0];
              r.flush_valid = 1'b1;
              r.flush_page  = slot_page[i];
              r.last        = (n == total);
              slot_dirty[i] = 1'b0;
              queue_reply(r);
            end
          end
        end
      end
      default: queue_reply(r);
    endcase
  endtask

  task automatic check_reply();
    dir_reply_t want;
    if (replies_due.size() == 0) begin
      report_mismatch("result with nothing due", {31'b0, out_last}, '0);
      return;
    end
    want = replies_due.pop_front();
    if (out_hit !== want.hit)
      report_mismatch("hit", 32'(out_hit), 32'(want.hit));
    if (out_slot !== want.slot)
      report_mismatch("slot", 32'(out_slot), 32'(want.slot));
    if (out_victim_valid !== want.victim_valid)
      report_mismatch("victim_valid", 32'(out_victim_valid), 32'(want.victim_valid));
    if (out_victim_page !== want.victim_page)
      report_mismatch("victim_page", out_victim_page, want.victim_page);
    if (out_victim_dirty !== want.victim_dirty)
      report_mismatch("victim_dirty", 32'(out_victim_dirty), 32'(want.victim_dirty));
    if (out_write_through !== want.write_through)
      report_mismatch("write_through", 32'(out_write_through), 32'(want.write_through));
    if (out_flush_valid !== want.flush_valid)
      report_mismatch("flush_valid", 32'(out_flush_valid), 32'(want.flush_valid));
    if (out_flush_page !== want.flush_page)
      report_mismatch("flush_page", out_flush_page, want.flush_page);
    if (out_last !== want.last)
      report_mismatch("last", 32'(out_last), 32'(want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_directory();
      mismatches = 0;
    end else begin
      // results first: a request taken at this edge cannot answer at it
      if (out_valid && !out_stall) check_reply();
      if (cfg_valid && cfg_ready) lim_reg = cfg_data;
      if (in_valid && !in_stall) apply_request(in_kind, in_page_id);
    end
    replies_pending = replies_due.size();
  end

endmodule

### tb/sv/tb_lru_page_cache_directory.sv
`timescale 1ns / 1ps

module tb_lru_page_cache_directory;

  // kind code the block must answer with an empty result: all flags and fields zero, last set
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  localparam int HOLD_CYCLES    = 200;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
  localparam int SEG_ITEMS      = 43;    // random requests per limit setting
  localparam int POOL_MAX       = 20;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [31:0] in_page_id;
  logic        out_valid;
  logic        out_stall;
  logic        out_hit;
  logic [3:0]  out_slot;
  logic        out_victim_valid;
  logic [31:0] out_victim_page;
  logic        out_victim_dirty;
  logic        out_write_through;
  logic        out_flush_valid;
  logic [31:0] out_flush_page;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;

  int mismatches;
  int replies_pending;

  // idling knobs, in percent of cycles
  int send_idle_pct;
  int recv_idle_pct;
  // raised by the stimulus, consumed by the receiver process
  logic hold_req;

  logic [31:0] page_pool [POOL_MAX];
  int          pool_size;
  logic [4:0]  seg_limit [6];

  lru_page_cache_directory dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_page_id        (in_page_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_victim_valid  (out_victim_valid),
    .out_victim_page   (out_victim_page),
    .out_victim_dirty  (out_victim_dirty),
    .out_write_through (out_write_through),
    .out_flush_valid   (out_flush_valid),
    .out_flush_page    (out_flush_page),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  // watches all three channels, predicts and compares
  lru_directory_checker dir_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_page_id        (in_page_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_victim_valid  (out_victim_valid),
    .out_victim_page   (out_victim_page),
    .out_victim_dirty  (out_victim_dirty),
    .out_write_through (out_write_through),
    .out_flush_valid   (out_flush_valid),
    .out_flush_page    (out_flush_page),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .replies_pending   (replies_pending)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random stall, or a long hold-off when asked for one
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog: ends the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL lru_page_cache_directory");
    $finish;
  end

  // one request transaction; returns at the accepting rising edge
  task automatic send_req(input logic [1:0] kind, input logic [31:0] page);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_page_id <= page;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender pauses until every predicted result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (replies_pending != 0) @(negedge clk);
    // extra settle time before the next step
    repeat (4) @(negedge clk);
  endtask

  // page limit write, only while the block is idle
  task automatic write_limit(input logic [4:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly pool pages so hits, dirty victims and flushes happen; some noise
  task automatic random_req();
    int pick;
    logic [31:0] page;
    pick = $urandom_range(99);
    page = page_pool[$urandom_range(pool_size - 1)];
    if (pick < 50)
      send_req(lpcd_pkg::KIND_READ, page);
    else if (pick < 80)
      send_req(lpcd_pkg::KIND_WRITE, page);
    else if (pick < 90)
      send_req(lpcd_pkg::KIND_FLUSH, $urandom);
    else if (pick < 94)
      send_req(KIND_UNKNOWN, page);
    else
      send_req(2'($urandom_range(3)), $urandom);
  endtask

  initial begin : stimulus
    int eff;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = lpcd_pkg::KIND_READ;
    in_page_id    = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    hold_req      = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 85;
    pool_size     = 1;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset limit of 16, field extremes, every kind
    send_req(lpcd_pkg::KIND_READ, 32'h0000_0000);      // miss into a free entry
    send_req(lpcd_pkg::KIND_READ, 32'hFFFF_FFFF);
    send_req(lpcd_pkg::KIND_READ, 32'h0000_0000);      // read hit
    send_req(lpcd_pkg::KIND_WRITE, 32'hFFFF_FFFF);     // write hit, now dirty
    send_req(lpcd_pkg::KIND_WRITE, 32'h1234_5678);     // write miss goes through
    send_req(lpcd_pkg::KIND_FLUSH, 32'hFFFF_FFFF);     // one dirty page
    send_req(lpcd_pkg::KIND_FLUSH, 32'h0000_0000);     // nothing dirty, single empty result
    send_req(KIND_UNKNOWN, 32'hFFFF_FFFF);             // unknown kind, no state change
    send_req(lpcd_pkg::KIND_WRITE, 32'h0000_0000);
    send_req(lpcd_pkg::KIND_WRITE, 32'hFFFF_FFFF);
    send_req(lpcd_pkg::KIND_READ, 32'hA5A5_A5A5);
    wait_drained();

    // limit lowered below the pages held: each miss evicts just one
    write_limit(5'd2);
    send_req(lpcd_pkg::KIND_READ, 32'h5A5A_5A5A);
    send_req(lpcd_pkg::KIND_READ, 32'h0000_0001);
    send_req(lpcd_pkg::KIND_READ, 32'h8000_0000);
    wait_drained();

    // zero acts as a limit of one
    write_limit(5'd0);
    send_req(lpcd_pkg::KIND_READ, 32'h7FFF_FFFF);
    send_req(lpcd_pkg::KIND_WRITE, 32'h7FFF_FFFF);
    send_req(lpcd_pkg::KIND_READ, 32'h7FFF_FFFF);
    send_req(lpcd_pkg::KIND_READ, 32'hDEAD_BEEF);      // evicts a clean page
    wait_drained();

    // all ones acts as full capacity
    write_limit(5'd31);
    send_req(lpcd_pkg::KIND_WRITE, 32'hDEAD_BEEF);
    send_req(lpcd_pkg::KIND_FLUSH, 32'h0000_0000);
    wait_drained();

    // random part: one limit setting per segment
    seg_limit[0] = 5'd16;
    seg_limit[1] = 5'd3;
    seg_limit[2] = 5'd0;
    seg_limit[3] = 5'd31;
    seg_limit[4] = 5'd1;
    seg_limit[5] = 5'($urandom_range(1, 16));
    for (int seg = 0; seg < 6; seg++) begin
      if (seg < 2) begin
        send_idle_pct = 16;
        recv_idle_pct = 85;
      end else if (seg < 4) begin
        send_idle_pct = 85;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_limit(seg_limit[seg]);
      eff = (seg_limit[seg] == 0) ? 1 :
            (seg_limit[seg] > lpcd_pkg::CAPACITY) ? lpcd_pkg::CAPACITY :
            int'(seg_limit[seg]);
      // a few more pages than fit, so evictions keep happening
      pool_size = (eff + 4 > POOL_MAX) ? POOL_MAX : eff + 4;
      for (int i = 0; i < POOL_MAX; i++) page_pool[i] = $urandom;

      if (seg == 0) begin
        // fill every entry, dirty them all, then one sweep with a full burst
        for (int i = 0; i < lpcd_pkg::CAPACITY; i++)
          send_req(lpcd_pkg::KIND_READ, page_pool[i]);
        for (int i = 0; i < lpcd_pkg::CAPACITY; i++)
          send_req(lpcd_pkg::KIND_WRITE, page_pool[i]);
        send_req(lpcd_pkg::KIND_FLUSH, $urandom);
      end

      for (int k = 0; k < SEG_ITEMS; k++) begin
        // long receiver hold-off while requests keep coming
        if (seg == 1 && k == 8) hold_req = 1'b1;
        random_req();
      end
      wait_drained();
    end

    // final quiet stretch past the latency
    repeat (8) @(posedge clk);
    if (mismatches == 0 && replies_pending == 0)
      $display("PASS lru_page_cache_directory");
    else
      $display("FAIL lru_page_cache_directory");
    $finish;
  end

endmodule
